FILE: rtl/core/etcd_pkg.sv
// Package for the epoch to calendar date converter.
// Holds shared widths, the offset reset value, the stage-to-stage struct and the year helper functions.
// No dependencies.
`default_nettype none
package etcd_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned OffW   = 17;
  localparam logic signed [OffW-1:0] OffReset = 17'sd25200;

  // days since 1970-01-01 for 2^32 seconds stay below 49711
  localparam int unsigned DayW   = 16;

  // first-stage result handed to the calendar unit
  typedef struct packed {
    logic [DayW-1:0] days;
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [2:0]      wday;
  } etcd_tod_t;

  // day number of Jan 1 of year 1970 + yo, 1970..2106
  // leap years before it: one per four years from 1972, less 2100 once past it
  function automatic logic [DayW-1:0] year_start(input logic [7:0] yo);
    logic [DayW-1:0] d;
    d = DayW'(yo) * DayW'(365) + DayW'((9'(yo) + 9'd1) >> 2);
    if (yo >= 8'd131) d = d - DayW'(1);
    return d;
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && ((y != 12'd1800) && (y != 12'd1900)
           && (y != 12'd2100) || (y == 12'd2000));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/epoch_to_calendar_date.sv
// Top level of the epoch to calendar date converter.
// Depends on etcd_pkg, etcd_tod and etcd_cal.
//
// channel | direction | handshake        | payload
// in_     | input     | in_valid/in_stall | epoch_seconds
// out_    | output    | out_valid/out_stall | year .. weekday
// cfg_    | input     | cfg_we           | cfg_utc_offset_sec
//
// Six register stages, one item per cycle while the output is not stalled.
// Depth is set by the reciprocal multiplies and the year estimate.
// Reset (synchronous) empties the pipeline and loads the offset 25200.
// A stall on a valid output freezes the whole pipeline; in_stall follows it.
`default_nettype none
module epoch_to_calendar_date (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic signed [16:0]               cfg_utc_offset_sec,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      in_epoch_seconds,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [11:0]                           out_year,
  output logic [3:0]                            out_month_index,
  output logic [4:0]                            out_day_of_month,
  output logic [4:0]                            out_hour_of_day,
  output logic [5:0]                            out_minute_of_hour,
  output logic [2:0]                            out_weekday
);

  logic signed [16:0]      off_r;
  logic                    adv;
  logic                    tv;
  etcd_pkg::etcd_tod_t     tod;
  etcd_pkg::etcd_tod_t     tod2;

  // offset register
  always_ff @(posedge clk) begin
    if (!rst_n) off_r <= etcd_pkg::OffReset;
    else if (cfg_we) off_r <= cfg_utc_offset_sec;
  end

  // pipeline moves unless a result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  etcd_tod u_tod (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid),
    .secs(in_epoch_seconds), .off(off_r), .vld_o(tv), .tod_o(tod)
  );

  etcd_cal u_cal (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(tv), .tod(tod),
    .vld_o(out_valid), .tod_o(tod2), .year_o(out_year),
    .month_o(out_month_index), .mday_o(out_day_of_month)
  );

  assign out_hour_of_day    = tod2.hour;
  assign out_minute_of_hour = tod2.minute;
  assign out_weekday        = tod2.wday;

endmodule
`default_nettype wire

FILE: rtl/core/etcd_tod.sv
// Time-of-day stages: offset add, then split into days, hour, minute, weekday.
// Depends on etcd_pkg.
`default_nettype none
module etcd_tod (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               adv,
  input  wire logic                               in_vld,
  input  wire logic [etcd_pkg::EpochW-1:0]        secs,
  input  wire logic signed [etcd_pkg::OffW-1:0]   off,
  output logic                                    vld_o,
  output etcd_pkg::etcd_tod_t                     tod_o
);

  logic                            v1_r, v2_r, v3_r, v4_r;
  logic [etcd_pkg::EpochW-1:0]     t_r;
  logic [26:0]                     min_r;   // t / 60
  logic [etcd_pkg::DayW-1:0]       hrs_day_r; // days
  logic [10:0]                     rday_r;  // minute of day
  etcd_pkg::etcd_tod_t             tod_r;

  logic [26:0] q60;
  logic [63:0] p60;
  logic [26:0] qadj;
  logic [31:0] back;
  logic [63:0] p1440;
  logic [15:0] q1440;
  logic [26:0] rem1440;
  logic [10:0] rday;
  logic [22:0] phr;
  logic [4:0]  hq;
  logic [5:0]  mq;
  logic [15:0] dq;
  logic [34:0] p7;
  logic [15:0] q7;
  logic [2:0]  w;

  // t / 60 by reciprocal; ceil(2^37/60) product, remainder check as guard
  assign p60  = {32'd0, t_r} * 64'd2290649225;
  assign qadj = p60[63:37];
  assign back = t_r - 32'(qadj) * 32'd60;
  always_comb begin
    q60 = qadj;
    if (back >= 32'd60) q60 = qadj + 27'd1;
  end

  // minutes / 1440 -> days, remainder minutes of day
  assign p1440 = {37'd0, min_r} * 64'd95443718;  // ceil(2^37/1440)
  always_comb begin
    q1440   = p1440[52:37];
    rem1440 = min_r - 27'(q1440) * 27'd1440;
    if (rem1440 >= 27'd1440) begin
      q1440   = q1440 + 16'd1;
      rem1440 = rem1440 - 27'd1440;
    end
    rday = rem1440[10:0];
  end

  // hour and minute from minute of day; ceil(2^17/60)
  assign phr = {12'd0, rday_r} * 23'd2185;
  assign hq  = 5'(phr >> 17);
  assign mq  = 6'(rday_r - 11'(hq) * 11'd60);

  // weekday from day count; ceil(2^21/7)
  assign dq = hrs_day_r + 16'd4;
  always_comb begin
    p7 = {19'd0, dq} * 35'd299594;
    q7 = 16'(p7 >> 21);
    w  = 3'(dq - q7 * 16'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r      <= secs + {{(etcd_pkg::EpochW-etcd_pkg::OffW){off[etcd_pkg::OffW-1]}}, off};
      min_r    <= q60;
      hrs_day_r <= q1440;
      rday_r   <= rday;
      tod_r.days   <= hrs_day_r;
      tod_r.hour   <= hq;
      tod_r.minute <= mq;
      tod_r.wday   <= w;
    end
  end

  assign vld_o = v4_r;
  assign tod_o = tod_r;

endmodule
`default_nettype wire

FILE: rtl/core/etcd_cal.sv
// Calendar stages: day count to year, month and day of month.
// Depends on etcd_pkg.
`default_nettype none
module etcd_cal (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_vld,
  input  etcd_pkg::etcd_tod_t       tod,
  output logic                      vld_o,
  output etcd_pkg::etcd_tod_t       tod_o,
  output logic [11:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                mday_o
);

  logic                   v1_r, v2_r;
  etcd_pkg::etcd_tod_t    t1_r, t2_r;
  logic [7:0]             yo_r;
  logic [8:0]             doy_r;
  logic                   leap_r;
  logic [3:0]             mon_r;
  logic [4:0]             mday_r;

  logic [15:0] dadj;
  logic [17:0] yx;
  logic [37:0] yp;
  logic [7:0]  yo;
  logic [15:0] ys;
  logic [11:0] yr;
  logic [8:0]  d;
  logic [3:0]  m;
  logic [8:0]  cum [13];

  // year: insert a virtual Feb 29 2100 (day 47541 is Mar 1 2100) so every
  // fourth year is leap, then yo = (4*days + 2) / 1461 via ceil(2^30/1461)
  always_comb begin
    dadj = tod.days + 16'(tod.days >= 16'd47541);
    yx   = {dadj, 2'b00} + 18'd2;
    yp   = {20'd0, yx} * 38'd734937;
    yo   = 8'(yp >> 30);
    ys   = etcd_pkg::year_start(yo);
  end

  // month from day of year by compare against cumulative lengths
  always_comb begin
    cum[0]  = 9'd0;   cum[1]  = 9'd31;  cum[2]  = 9'd59;  cum[3]  = 9'd90;
    cum[4]  = 9'd120; cum[5]  = 9'd151; cum[6]  = 9'd181; cum[7]  = 9'd212;
    cum[8]  = 9'd243; cum[9]  = 9'd273; cum[10] = 9'd304; cum[11] = 9'd334;
    cum[12] = 9'd365;
    for (int i = 2; i < 13; i++) cum[i] = cum[i] + 9'(leap_r);
    m = 4'd0;
    for (int i = 1; i < 12; i++) if (doy_r >= cum[i]) m = 4'(i);
    d = doy_r - cum[m];
  end

  assign yr = 12'd1970 + {4'd0, yo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= tod;
      yo_r   <= yo;
      doy_r  <= 9'(tod.days - ys);
      leap_r <= etcd_pkg::is_leap(12'd1970 + {4'd0, yo});
      t2_r   <= t1_r;
      mon_r  <= m;
      mday_r <= 5'(d + 9'd1);
      year_o <= yr;
    end
  end

  assign vld_o   = v2_r;
  assign tod_o   = t2_r;
  assign month_o = mon_r;
  assign mday_o  = mday_r;

endmodule
`default_nettype wire
